>>> design/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg: shared types and constants for the lifo stack engine
// command codes, status codes, sequencer states and the queued command word
// ----------------------------------------------------------------------------
package lse_pkg;

	localparam int unsigned ModeW    = 3;
	localparam int unsigned WordW    = 32;
	localparam int unsigned FillW    = 7;
	localparam int unsigned StatusW  = 2;
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 48;

	// command queue between front and back
	localparam int unsigned QDepth = 2;
	localparam int unsigned QPtrW  = 1;
	localparam int unsigned QCntW  = 2;

	// raw mode codes on the input beat
	localparam logic [ModeW-1:0] MODE_PUSH    = 3'd0;
	localparam logic [ModeW-1:0] MODE_POP     = 3'd1;
	localparam logic [ModeW-1:0] MODE_CLEAR   = 3'd2;
	localparam logic [ModeW-1:0] MODE_PEEK    = 3'd3;
	localparam logic [ModeW-1:0] MODE_REMOVE  = 3'd4;
	localparam logic [ModeW-1:0] MODE_REVERSE = 3'd5;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_POP,
		OP_CLEAR,
		OP_PEEK,
		OP_REMOVE,
		OP_REVERSE,
		OP_NOP
	} op_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SR_RD,
		S_SR_CMP,
		S_SH_RD,
		S_SH_WR,
		S_RV_RDLO,
		S_RV_RDHI,
		S_RV_WRLO,
		S_RV_WRHI,
		S_FETCH,
		S_FINISH
	} state_t;

	typedef struct packed {
		op_t                     op;
		logic signed [WordW-1:0] operand;
	} cmd_t;

	// classify a raw mode code
	function automatic op_t decode_mode(input logic [ModeW-1:0] mode);
		op_t op;
		case (mode)
			MODE_PUSH:    op = OP_PUSH;
			MODE_POP:     op = OP_POP;
			MODE_CLEAR:   op = OP_CLEAR;
			MODE_PEEK:    op = OP_PEEK;
			MODE_REMOVE:  op = OP_REMOVE;
			MODE_REVERSE: op = OP_REVERSE;
			default:      op = OP_NOP;
		endcase
		return op;
	endfunction

endpackage

>>> design/lifo_stack_engine_top.sv
// ----------------------------------------------------------------------------
// lifo_stack_engine_top: bounded last-in-first-out store of signed words
// Commands enter on the s_axis channel, one per beat: mode in the low three
//   bits (push, pop, clear, peek, remove value, reverse), operand above it.
// Every command returns exactly one beat on m_axis: top entry, its validity,
//   the fill count and a status (ok, empty, full, value not found).
// A two-entry command queue sits in front of the execution sequencer, so
//   input beats are taken while a command runs or a result waits.
// Push, pop, clear, peek: the sequencer passes through its idle, fetch and finish states and
//   registers the result. Remove value: entries are searched from the top, each with a read and
//   a compare state, then every entry above the match is moved down, each with a read and a write.
// Reverse: entries are swapped in pairs from the ends inward, each pair read and written back crosswise.
// The pace is set by the single read and single write port of the entry memory.
// Commands run one at a time in arrival order.
// Reset empties the store at once (fill count to zero, no clearing pass) and
//   flushes the queue; memory contents are left as they are.
// When m_axis is stalled the result is held in its output register; the queue
//   keeps taking beats until it is full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module lifo_stack_engine_top #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [2:0] mode, [34:3] operand_value, [39:35] zero
	input  logic [lse_pkg::InDataW-1:0]  s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [31:0] top_value, [32] top_valid, [39:33] fill_count, [41:40] status,
	// [47:42] zero
	output logic [lse_pkg::OutDataW-1:0] m_axis_tdata
);
	import lse_pkg::*;

	cmd_t                    cmd;
	logic                    cmd_valid;
	logic                    cmd_ready;
	logic signed [WordW-1:0] res_top_value;
	logic                    res_top_valid;
	logic [FillW-1:0]        res_fill_count;
	status_t                 res_status;

	// intake and classification
	lse_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd)
	);

	// execution against the entry memory
	lse_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.res_valid      (m_axis_tvalid),
		.res_ready      (m_axis_tready),
		.res_top_value  (res_top_value),
		.res_top_valid  (res_top_valid),
		.res_fill_count (res_fill_count),
		.res_status     (res_status)
	);

	// pack the result beat
	assign m_axis_tdata = {
		{(OutDataW - WordW - 1 - FillW - StatusW){1'b0}},
		res_status,
		res_fill_count,
		res_top_valid,
		res_top_value
	};

endmodule

>>> design/lse_ram.sv
// ----------------------------------------------------------------------------
// lse_ram: generic single-write single-read memory
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module lse_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/lse_front.sv
// ----------------------------------------------------------------------------
// lse_front: command intake
// accepts input beats, classifies the mode and queues commands for the back end
// ----------------------------------------------------------------------------
module lse_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// [2:0] mode, [34:3] operand_value, [39:35] zero
	input  logic [lse_pkg::InDataW-1:0] s_axis_tdata,
	output logic                       cmd_valid,
	input  logic                       cmd_ready,
	output lse_pkg::cmd_t              cmd
);
	import lse_pkg::*;

	cmd_t             slot_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;
	logic             push;
	logic             pop;
	cmd_t             in_cmd;

	// classify the incoming beat
	assign in_cmd.op      = decode_mode(s_axis_tdata[ModeW-1:0]);
	assign in_cmd.operand = s_axis_tdata[ModeW+WordW-1:ModeW];

	assign s_axis_tready = (cnt_q != QCntW'(QDepth));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign cmd_valid     = (cnt_q != '0);
	assign pop           = cmd_valid && cmd_ready;
	assign cmd           = slot_q[rd_ptr_q];

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

>>> design/lse_back.sv
// ----------------------------------------------------------------------------
// lse_back: command execution
// runs each queued command against the entry memory and registers the result
// ----------------------------------------------------------------------------
module lse_back #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  lse_pkg::cmd_t                       cmd,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic signed [lse_pkg::WordW-1:0]    res_top_value,
	output logic                                res_top_valid,
	output logic [lse_pkg::FillW-1:0]           res_fill_count,
	output lse_pkg::status_t                    res_status
);
	import lse_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = CW + 1;

	state_t           state_q;
	state_t           state_d;
	logic [CW-1:0]    count_q;
	status_t          status_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    hi_q;
	logic [WordW-1:0] key_q;
	logic [WordW-1:0] tmp_q;
	logic             out_valid_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [WordW-1:0] wdata;
	logic [AW-1:0]    raddr;
	logic [WordW-1:0] rdata;

	logic             empty;
	logic             full;
	logic [CW-1:0]    count_m1;
	logic [AW-1:0]    top_idx;
	logic [AW-1:0]    idx_p1;
	logic             shift_more;
	logic             rev_more;
	logic             match;
	logic             out_load;
	logic [CW+FillW-1:0] count_ext;

	lse_ram #(
		.WIDTH (WordW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// status of the store and loop conditions
	assign empty      = (count_q == '0);
	assign full       = (count_q == CW'(DEPTH));
	assign count_m1   = count_q - 1'b1;
	assign top_idx    = count_m1[AW-1:0];
	assign idx_p1     = idx_q + 1'b1;
	assign shift_more = (XW'(idx_q) + XW'(1)) < XW'(count_q);
	assign rev_more   = XW'(hi_q) > (XW'(idx_q) + XW'(2));
	assign match      = (rdata == key_q);
	assign out_load   = (state_q == S_FINISH) && (!out_valid_q || res_ready);
	assign count_ext  = {{FillW{1'b0}}, count_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_REMOVE: state_d = empty ? S_FETCH : S_SR_RD;
						OP_REVERSE: state_d = (count_q > CW'(1)) ? S_RV_RDLO : S_FETCH;
						default: state_d = S_FETCH;
					endcase
				end
			end
			S_SR_RD: state_d = S_SR_CMP;
			S_SR_CMP: begin
				if (match) begin
					state_d = S_SH_RD;
				end else if (idx_q == '0) begin
					state_d = S_FETCH;
				end else begin
					state_d = S_SR_RD;
				end
			end
			S_SH_RD:   state_d = shift_more ? S_SH_WR : S_FETCH;
			S_SH_WR:   state_d = S_SH_RD;
			S_RV_RDLO: state_d = S_RV_RDHI;
			S_RV_RDHI: state_d = S_RV_WRLO;
			S_RV_WRLO: state_d = S_RV_WRHI;
			S_RV_WRHI: state_d = rev_more ? S_RV_RDLO : S_FETCH;
			S_FETCH:   state_d = S_FINISH;
			S_FINISH:  state_d = out_load ? S_IDLE : S_FINISH;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory controls and command pull
	always_comb begin
		cmd_ready = 1'b0;
		we        = 1'b0;
		waddr     = idx_q;
		wdata     = rdata;
		raddr     = top_idx;
		case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid && (cmd.op == OP_PUSH) && !full) begin
					we    = 1'b1;
					waddr = count_q[AW-1:0];
					wdata = cmd.operand;
				end
			end
			S_SR_RD:   raddr = idx_q;
			S_SR_CMP:  raddr = idx_q;
			S_SH_RD:   raddr = idx_p1;
			S_SH_WR: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = rdata;
			end
			S_RV_RDLO: raddr = idx_q;
			S_RV_RDHI: raddr = hi_q;
			S_RV_WRLO: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = rdata;
			end
			S_RV_WRHI: begin
				we    = 1'b1;
				waddr = hi_q;
				wdata = tmp_q;
			end
			default: begin
				raddr = top_idx;
			end
		endcase
	end

	// control registers: state, fill count, status, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						status_q <= ST_OK;
						case (cmd.op)
							OP_PUSH: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							OP_POP: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									count_q <= count_m1;
								end
							end
							OP_CLEAR: count_q <= '0;
							OP_PEEK: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end
							end
							OP_REMOVE: begin
								if (empty) begin
									status_q <= ST_NOTFOUND;
								end
							end
							default: begin
								status_q <= ST_OK;
							end
						endcase
					end
				end
				S_SR_CMP: begin
					if (!match && (idx_q == '0)) begin
						status_q <= ST_NOTFOUND;
					end
				end
				S_SH_RD: begin
					if (!shift_more) begin
						count_q <= count_m1;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk indices and held words
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q <= cmd.operand;
				if (cmd.op == OP_REVERSE) begin
					idx_q <= '0;
				end else begin
					idx_q <= top_idx;
				end
				hi_q <= top_idx;
			end
			S_SR_CMP: begin
				if (!match && (idx_q != '0)) begin
					idx_q <= idx_q - 1'b1;
				end
			end
			S_SH_WR:   idx_q <= idx_p1;
			S_RV_RDHI: tmp_q <= rdata;
			S_RV_WRHI: begin
				idx_q <= idx_p1;
				hi_q  <= hi_q - 1'b1;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_top_value  <= empty ? '0 : rdata;
			res_top_valid  <= !empty;
			res_fill_count <= count_ext[FillW-1:0];
			res_status     <= status_q;
		end
	end

	assign res_valid = out_valid_q;

endmodule
